/* rtl/ud_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ud_pkg
// Shared types and constants for the unsigned integer divider.
// ----------------------------------------------------------------------------
package ud_pkg;

    localparam int OPND_BITS = 32;   // width of dividend and divisor ports
    localparam int QUOT_BITS = 32;   // width of quotient port

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } ud_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture operands, clear partial remainder
        logic step;     // one restoring division iteration
        logic finish;   // move quotient into the output register
    } ud_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;     // current iteration is the final one
    } ud_status_t;

endpackage

/* rtl/unsigned_integer_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_integer_divider
// Restoring shift-and-subtract divider giving the truncated unsigned quotient.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries s_dividend and s_divisor; the
//   transaction is taken when both are high. Result channel m_valid/m_ready
//   carries m_quotient. A zero divisor returns zero with no flag.
//   Operands are reduced modulo 2^WORD_BITS before dividing.
// Timing:
//   One quotient bit per cycle from a single shared subtract/compare unit.
//   After acceptance the divider runs one iteration per quotient bit, then
//   writes the output register in its finish step, which raises m_valid.
//   A new transaction is taken only once the divider has returned to idle,
//   so it does not accept the next division while one is in progress.
// Stall behavior:
//   The output register holds a finished quotient while the next division
//   runs. If that quotient is still untaken when the next one completes,
//   the divider waits in its finish step and s_ready stays low.
// Reset:
//   aresetn (synchronous, active low) returns to idle with no result pending.
// ----------------------------------------------------------------------------
module unsigned_integer_divider #(
    parameter int WORD_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ud_pkg::OPND_BITS-1:0] s_dividend,
    input  logic [ud_pkg::OPND_BITS-1:0] s_divisor,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ud_pkg::QUOT_BITS-1:0] m_quotient
);
    import ud_pkg::*;

    ud_cmd_t    cmd;
    ud_status_t status;

    ud_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ud_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_dividend (s_dividend),
        .s_divisor  (s_divisor),
        .m_quotient (m_quotient)
    );

endmodule

/* rtl/ud_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ud_datapath
// Operand registers, shared subtractor, iteration counter and result register.
// ----------------------------------------------------------------------------
module ud_datapath #(
    parameter int WORD_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ud_pkg::ud_cmd_t              cmd,
    output ud_pkg::ud_status_t           status,
    input  logic [ud_pkg::OPND_BITS-1:0] s_dividend,
    input  logic [ud_pkg::OPND_BITS-1:0] s_divisor,
    output logic [ud_pkg::QUOT_BITS-1:0] m_quotient
);
    import ud_pkg::*;

    localparam int EXT_BITS = (WORD_BITS > OPND_BITS) ? WORD_BITS : OPND_BITS;
    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] num_reg, num_next;
    logic [WORD_BITS-1:0] den_reg, den_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [QUOT_BITS-1:0] quot_reg, quot_next;

    logic [EXT_BITS-1:0]  dividend_ext, divisor_ext, quo_ext;
    logic [WORD_BITS:0]   partial;
    logic [WORD_BITS:0]   diff;
    logic                 fits;

    // operands are taken modulo 2^WORD_BITS
    assign dividend_ext = EXT_BITS'(s_dividend);
    assign divisor_ext  = EXT_BITS'(s_divisor);

    // shifted remainder keeps the bit pushed out of the top (carry out)
    assign partial = {rem_reg, num_reg[WORD_BITS-1]};
    assign diff    = partial - {1'b0, den_reg};
    assign fits    = (partial >= {1'b0, den_reg});

    // zero divisor gives zero, not all ones
    assign quo_ext = (den_reg == '0) ? '0 : EXT_BITS'(quo_reg);

    assign status.last = (cnt_reg == '0);
    assign m_quotient  = quot_reg;

    always_comb begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        if (cmd.load) begin
            num_next = dividend_ext[WORD_BITS-1:0];
            den_next = divisor_ext[WORD_BITS-1:0];
            rem_next = '0;
            quo_next = '0;
            cnt_next = CNT_BITS'(WORD_BITS - 1);
        end else if (cmd.step) begin
            num_next = {num_reg[WORD_BITS-2:0], 1'b0};
            rem_next = fits ? diff[WORD_BITS-1:0] : partial[WORD_BITS-1:0];
            quo_next = {quo_reg[WORD_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.finish) begin
            quot_next = quo_ext[QUOT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
        quot_reg <= quot_next;
    end

    // remainder stays below a nonzero divisor after each iteration
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.step) && (den_reg != '0) |-> rem_reg < den_reg)
        else $error("partial remainder not below divisor");

    a_load_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (rem_reg == '0) && (quo_reg == '0))
        else $error("load did not clear partial results");

    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && !status.last |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("iteration counter did not advance");

endmodule

/* rtl/ud_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ud_ctrl
// Sequencer for the divider: load, iterate, hand the result to the output.
// ----------------------------------------------------------------------------
module ud_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output ud_pkg::ud_cmd_t     cmd,
    input  ud_pkg::ud_status_t  status
);
    import ud_pkg::*;

    ud_state_t state_reg, state_next;
    logic      out_valid_reg, out_valid_next;
    logic      out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (status.last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // wait here until the output register can take the result
                if (out_free) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_accept_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_RUN)
        else $error("accepted transaction did not start iterating");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> out_free)
        else $error("result overwrote an untaken transaction");

    a_last_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN && status.last |=> state_reg == ST_FINISH)
        else $error("final iteration did not lead to finish");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result valid raised outside finish");

endmodule

/* tb/quotient_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quotient_checker
// Watches both channels of the divider, predicts each quotient with its own
// restoring division, and compares results in order against the predictions.
// ----------------------------------------------------------------------------
module quotient_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [ud_pkg::OPND_BITS-1:0] s_dividend,
    input  logic [ud_pkg::OPND_BITS-1:0] s_divisor,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [ud_pkg::QUOT_BITS-1:0] m_quotient,
    output int                           fail_count,
    output int                           pending
);

    localparam int OB = ud_pkg::OPND_BITS;
    localparam int QB = ud_pkg::QUOT_BITS;

    typedef struct {
        logic [OB-1:0] dividend;
        logic [OB-1:0] divisor;
        logic [QB-1:0] quotient;
    } division_t;

    division_t quotient_q[$];
    int        errors = 0;

    // One quotient bit per step, MSB first; the extra partial-remainder bit
    // stands in for the carry out of the shifted remainder.
    function automatic logic [QB-1:0] restoring_quotient(input logic [OB-1:0] num,
                                                         input logic [OB-1:0] den);
        logic [OB:0]   part;
        logic [QB-1:0] quo;
        part = '0;
        quo  = '0;
        if (den == '0)
            return '0;
        for (int i = OB - 1; i >= 0; i--) begin
            part = {part[OB-1:0], num[i]};
            quo  = quo << 1;
            if (part >= {1'b0, den}) begin
                part   = part - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    always @(posedge aclk) begin
        division_t exp_div;
        division_t new_div;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (quotient_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected quotient transaction: expected none, actual %h",
                             $time, m_quotient);
                end else begin
                    exp_div = quotient_q.pop_front();
                    if (m_quotient !== exp_div.quotient) begin
                        errors++;
                        $display("%0t: quotient mismatch for %h / %h: expected %h, actual %h",
                                 $time, exp_div.dividend, exp_div.divisor,
                                 exp_div.quotient, m_quotient);
                    end
                end
            end
            if (s_valid && s_ready) begin
                new_div.dividend = s_dividend;
                new_div.divisor  = s_divisor;
                new_div.quotient = restoring_quotient(s_dividend, s_divisor);
                quotient_q.push_back(new_div);
            end
        end
        fail_count <= errors;
        pending    <= quotient_q.size();
    end

endmodule

/* tb/unsigned_integer_divider_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_integer_divider_tb
// Drives directed corner divisions and then randomized operand mixes into the
// divider with random gaps and output stalls; a checker compares quotients.
// ----------------------------------------------------------------------------
module unsigned_integer_divider_tb;

    localparam int OB = ud_pkg::OPND_BITS;
    localparam int QB = ud_pkg::QUOT_BITS;
    localparam logic [OB-1:0] ALL_ONES = '1;
    localparam logic [OB-1:0] TOP_BIT  = {1'b1, {(OB-1){1'b0}}};

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic [OB-1:0] s_dividend;
    logic [OB-1:0] s_divisor;
    logic          m_valid;
    logic          m_ready;
    logic [QB-1:0] m_quotient;
    int            fail_count;
    int            pending;
    logic          steady;

    unsigned_integer_divider uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_dividend (s_dividend),
        .s_divisor  (s_divisor),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_quotient (m_quotient)
    );

    quotient_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_dividend (s_dividend),
        .s_divisor  (s_divisor),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_quotient (m_quotient),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("unsigned_integer_divider_tb: FAIL");
        $finish;
    end

    // Mostly short gaps, a few long ones; none during a steady stretch.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 40);
        return $urandom_range(50, 200);
    endfunction

    task automatic send_division(input logic [OB-1:0] num, input logic [OB-1:0] den);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_dividend <= num;
        s_divisor  <= den;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // one edge first so the count includes the transaction just accepted
    task automatic drain_quotients();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    task automatic send_random_division();
        logic [OB-1:0] num;
        logic [OB-1:0] den;
        num = $urandom;
        den = $urandom;
        case ($urandom_range(0, 9))
            3: den = $urandom_range(1, 255);
            4: den = den >> $urandom_range(0, OB - 1);
            5: den = num + $urandom_range(0, 4) - 2;
            6: num = num >> $urandom_range(8, OB - 1);
            7: den = $urandom_range(0, 1);
            8: den = TOP_BIT >> $urandom_range(0, OB - 1);
            9: begin
                num = num >> $urandom_range(0, OB - 1);
                den = den >> $urandom_range(0, OB - 1);
            end
            default: ;
        endcase
        send_division(num, den);
    endtask

    // Result side: ready bursts and stalls, always ready in steady stretches
    initial begin
        int run;
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (steady) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                run = $urandom_range(1, 20);
                m_ready <= 1'b1;
                repeat (run) @(posedge aclk);
                stall = idle_cycles();
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_dividend = '0;
        s_divisor  = '0;
        steady     = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner cases: zero operands, divide by one, divisor above dividend
        send_division('0, '0);
        send_division('0, 32'd5);
        send_division(32'd5, '0);
        send_division(ALL_ONES, '0);
        send_division('0, ALL_ONES);
        send_division(ALL_ONES, 32'd1);
        send_division(TOP_BIT, 32'd1);
        send_division(32'd1, 32'd1);
        send_division(ALL_ONES, ALL_ONES);
        send_division(ALL_ONES - 1, ALL_ONES);
        send_division(32'd1, ALL_ONES);
        send_division(32'd3, 32'd7);
        send_division(ALL_ONES, 32'd2);
        send_division(ALL_ONES, TOP_BIT);
        send_division(TOP_BIT, ALL_ONES);
        send_division(TOP_BIT - 1, TOP_BIT);
        send_division(32'd7, 32'd3);
        send_division(32'd100, 32'd10);
        send_division(32'h1234_5678, 32'h0000_0100);
        send_division(32'hAAAA_AAAA, 32'h5555_5555);
        send_division(32'h5555_5555, 32'hAAAA_AAAA);
        send_division(ALL_ONES, 32'd3);
        drain_quotients();

        for (int n = 0; n < 1100; n++) begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (n == 550)
                drain_quotients();
            send_random_division();
        end
        drain_quotients();

        repeat (80) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("unsigned_integer_divider_tb: PASS");
        end else begin
            $display("unsigned_integer_divider_tb: FAIL");
        end
        $finish;
    end

endmodule

/* unsigned_integer_divider.f */
rtl/ud_pkg.sv
rtl/ud_datapath.sv
rtl/ud_ctrl.sv
rtl/unsigned_integer_divider.sv
tb/quotient_checker.sv
tb/unsigned_integer_divider_tb.sv
